>>> src/crcfr_pkg.sv
// ---------------------------------------------------------------------------
// crcfr_pkg: shared types and constants
// Codes, widths and the item format used by the framed ring store.
// ---------------------------------------------------------------------------
package crcfr_pkg;

   localparam int RING_DEPTH = 1024;
   localparam int ADDR_W     = $clog2(RING_DEPTH);
   localparam int PTR_W      = ADDR_W + 1;

   localparam logic [1:0] ACT_BEGIN_WRITE = 2'd0;
   localparam logic [1:0] ACT_WRITE_BYTE  = 2'd1;
   localparam logic [1:0] ACT_BEGIN_READ  = 2'd2;
   localparam logic [1:0] ACT_READ_BYTE   = 2'd3;

   localparam logic [3:0] ST_OK        = 4'd0;
   localparam logic [3:0] ST_EMPTY     = 4'd1;
   localparam logic [3:0] ST_CAPACITY  = 4'd2;
   localparam logic [3:0] ST_RING      = 4'd3;
   localparam logic [3:0] ST_CRC       = 4'd4;
   localparam logic [3:0] ST_TOO_BIG   = 4'd5;
   localparam logic [3:0] ST_ZERO_LEN  = 4'd6;
   localparam logic [3:0] ST_NO_ROOM   = 4'd7;
   localparam logic [3:0] ST_SEQUENCE  = 4'd8;

   typedef struct packed {
      logic begin_write;
      logic write_byte;
      logic begin_read;
      logic read_byte;
   } kind_type;

   typedef struct packed {
      kind_type    kind;
      logic [7:0]  data_in;
      logic [15:0] length;
   } item_type;

endpackage

>>> src/crcfr_front.sv
// ---------------------------------------------------------------------------
// crcfr_front: request intake
// Decodes each request beat and holds it in a two-entry queue for the back.
// ---------------------------------------------------------------------------
module crcfr_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [1:0]          req_action,
   input  logic [7:0]          req_data_in,
   input  logic [15:0]         req_length,
   input  logic                clearing,
   output logic                q_valid,
   output crcfr_pkg::item_type q_item,
   input  logic                q_pop
);

   crcfr_pkg::item_type entry_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       push;
   crcfr_pkg::item_type new_item;

   assign req_ready = (count_ff != 2'd2) && !clearing;
   assign push      = req_valid && req_ready;
   assign q_valid   = (count_ff != 2'd0);
   assign q_item    = entry_ff[rd_ptr_ff];

   always_comb begin
      new_item.kind.begin_write = (req_action == crcfr_pkg::ACT_BEGIN_WRITE);
      new_item.kind.write_byte  = (req_action == crcfr_pkg::ACT_WRITE_BYTE);
      new_item.kind.begin_read  = (req_action == crcfr_pkg::ACT_BEGIN_READ);
      new_item.kind.read_byte   = (req_action == crcfr_pkg::ACT_READ_BYTE);
      new_item.data_in          = req_data_in;
      new_item.length           = req_length;
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = q_pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, push} - {1'b0, q_pop};
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= new_item;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

>>> src/crcfr_back.sv
// ---------------------------------------------------------------------------
// crcfr_back: frame engine
// Sequencer over the ring memory: free check, framing, CRC and clearing.
// ---------------------------------------------------------------------------
module crcfr_back (
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_valid,
   input  logic [10:0]         csr_ring_bytes,
   output logic                clearing,
   input  logic                q_valid,
   input  crcfr_pkg::item_type q_item,
   output logic                q_pop,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [3:0]          rsp_status,
   output logic [7:0]          rsp_data_out,
   output logic [15:0]         rsp_obj_len,
   output logic                rsp_last,
   output logic [31:0]         rsp_write_errors
);

   localparam int AW = crcfr_pkg::ADDR_W;
   localparam int PW = crcfr_pkg::PTR_W;

   localparam logic [4:0] S_CLEAR = 5'd0;
   localparam logic [4:0] S_IDLE  = 5'd1;
   localparam logic [4:0] S_SCAN  = 5'd2;
   localparam logic [4:0] S_HDR1  = 5'd3;
   localparam logic [4:0] S_WCRC0 = 5'd4;
   localparam logic [4:0] S_WCRC1 = 5'd5;
   localparam logic [4:0] S_RH1   = 5'd6;
   localparam logic [4:0] S_RH2   = 5'd7;
   localparam logic [4:0] S_RB1   = 5'd8;
   localparam logic [4:0] S_RC1   = 5'd9;
   localparam logic [4:0] S_RC2   = 5'd10;
   localparam logic [4:0] S_RZ1   = 5'd11;
   localparam logic [4:0] S_RZ2   = 5'd12;
   localparam logic [4:0] S_ZERO  = 5'd13;

   localparam logic [1:0] M_IDLE  = 2'd0;
   localparam logic [1:0] M_WRITE = 2'd1;
   localparam logic [1:0] M_READ  = 2'd2;

   function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] d);
      logic [15:0] c;
      logic [7:0]  x;
      c = crc;
      x = d;
      for (int i = 0; i < 8; i++) begin
         if (c[0] ^ x[0]) c = (c >> 1) ^ 16'h8408;
         else c = c >> 1;
         x = x >> 1;
      end
      return c;
   endfunction

   function automatic logic [AW-1:0] wrap_ptr(input logic [PW-1:0] p, input logic [PW-1:0] sz);
      return (p >= sz) ? '0 : p[AW-1:0];
   endfunction

   logic [7:0]    mem [crcfr_pkg::RING_DEPTH];
   logic [7:0]    rd_data_ff;
   logic          mem_we, mem_re;
   logic [AW-1:0] mem_addr;
   logic [7:0]    mem_wd;

   logic [4:0]  state_ff, state_in;
   logic [1:0]  mode_ff, mode_in;
   logic [PW-1:0] wptr_ff, wptr_in, rptr_ff, rptr_in, cur_ff, cur_in, tp_ff, tp_in;
   logic [PW-1:0] cnt_ff, cnt_in;
   logic [15:0] bl_ff, bl_in, crc_ff, crc_in, len_ff, len_in;
   logic [31:0] err_ff, err_in;
   logic        pend_ff, pend_in;
   logic [7:0]  lo_ff, lo_in, s0_ff, s0_in, dout_ff, dout_in;
   logic [10:0] ring_ff;
   logic        rv_ff, rv_in, last_ff, last_in;
   logic [3:0]  st_ff, st_in;
   logic [7:0]  od_ff, od_in;
   logic [15:0] ol_ff, ol_in;

   logic [PW-1:0] size;
   logic [AW-1:0] a;
   logic [PW-1:0] a_next;
   logic [15:0]   bl_dec, crc_new, chk, osz;
   logic [16:0]   flen;

   assign clearing         = (state_ff == S_CLEAR);
   assign rsp_valid        = rv_ff;
   assign rsp_status       = st_ff;
   assign rsp_data_out     = od_ff;
   assign rsp_obj_len      = ol_ff;
   assign rsp_last         = last_ff;
   assign rsp_write_errors = err_ff;

   always_comb begin
      if (ring_ff < 11'd8) size = 11'd8;
      else if (ring_ff > 11'(crcfr_pkg::RING_DEPTH)) size = 11'(crcfr_pkg::RING_DEPTH);
      else size = ring_ff;
   end

   always_comb begin
      state_in = state_ff; mode_in = mode_ff;
      wptr_in = wptr_ff; rptr_in = rptr_ff; cur_in = cur_ff; tp_in = tp_ff;
      cnt_in = cnt_ff; bl_in = bl_ff; crc_in = crc_ff; len_in = len_ff;
      err_in = err_ff; pend_in = 1'b0; lo_in = lo_ff; s0_in = s0_ff; dout_in = dout_ff;
      rv_in = rv_ff && !rsp_ready;
      st_in = st_ff; od_in = od_ff; ol_in = ol_ff; last_in = last_ff;
      mem_we = 1'b0; mem_re = 1'b0; mem_addr = '0; mem_wd = 8'd0;
      q_pop = 1'b0;
      a = '0; a_next = '0; flen = '0;
      bl_dec  = bl_ff - 16'd1;
      crc_new = crc_ff;
      chk     = ~crc_ff;
      osz     = {rd_data_ff, lo_ff};

      unique case (state_ff)
         S_CLEAR: begin
            mem_we   = 1'b1;
            mem_addr = tp_ff[AW-1:0];
            tp_in    = tp_ff + 1'b1;
            if (tp_ff == PW'(crcfr_pkg::RING_DEPTH - 1)) begin
               tp_in    = '0;
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (q_valid && !rv_ff) begin
               q_pop  = 1'b1;
               len_in = q_item.length;
               st_in = crcfr_pkg::ST_SEQUENCE; od_in = 8'd0; ol_in = 16'd0; last_in = 1'b0;
               priority if (q_item.kind.begin_write && mode_ff == M_IDLE) begin
                  if (q_item.length > (16'(size) - 16'd4)) begin
                     rv_in = 1'b1; st_in = crcfr_pkg::ST_TOO_BIG; err_in = err_ff + 32'd1;
                  end else if (q_item.length == 16'd0) begin
                     rv_in = 1'b1; st_in = crcfr_pkg::ST_ZERO_LEN; err_in = err_ff + 32'd1;
                  end else begin
                     tp_in    = wptr_ff;
                     cnt_in   = PW'(q_item.length) + PW'(6);
                     state_in = S_SCAN;
                  end
               end else if (q_item.kind.write_byte && mode_ff == M_WRITE) begin
                  a        = wrap_ptr(cur_ff, size);
                  mem_we   = 1'b1; mem_addr = a; mem_wd = q_item.data_in;
                  cur_in   = {1'b0, a} + 1'b1;
                  crc_in   = crc_byte(crc_ff, q_item.data_in);
                  bl_in    = bl_dec;
                  if (bl_dec == 16'd0) state_in = S_WCRC0;
                  else begin
                     rv_in = 1'b1; st_in = crcfr_pkg::ST_OK;
                  end
               end else if (q_item.kind.begin_read && mode_ff == M_IDLE) begin
                  a        = wrap_ptr(rptr_ff, size);
                  mem_re   = 1'b1; mem_addr = a;
                  tp_in    = {1'b0, a} + 1'b1;
                  state_in = S_RH1;
               end else if (q_item.kind.read_byte && mode_ff == M_READ) begin
                  a        = wrap_ptr(cur_ff, size);
                  mem_re   = 1'b1; mem_addr = a;
                  cur_in   = {1'b0, a} + 1'b1;
                  state_in = S_RB1;
               end else begin
                  rv_in = 1'b1;
               end
            end
         end
         S_SCAN: begin
            if (pend_ff && rd_data_ff != 8'd0) begin
               rv_in = 1'b1; st_in = crcfr_pkg::ST_NO_ROOM; err_in = err_ff + 32'd1;
               state_in = S_IDLE;
            end else if (cnt_ff != '0) begin
               a       = wrap_ptr(tp_ff, size);
               mem_re  = 1'b1; mem_addr = a;
               tp_in   = {1'b0, a} + 1'b1;
               cnt_in  = cnt_ff - 1'b1;
               pend_in = 1'b1;
            end else if (!pend_ff) begin
               // room confirmed: lay down the low header byte
               a        = wrap_ptr(wptr_ff, size);
               mem_we   = 1'b1; mem_addr = a; mem_wd = len_ff[7:0];
               cur_in   = {1'b0, a} + 1'b1;
               state_in = S_HDR1;
            end
         end
         S_HDR1: begin
            a        = wrap_ptr(cur_ff, size);
            mem_we   = 1'b1; mem_addr = a; mem_wd = len_ff[15:8];
            cur_in   = {1'b0, a} + 1'b1;
            bl_in    = len_ff; crc_in = 16'hFFFF; mode_in = M_WRITE;
            rv_in    = 1'b1; st_in = crcfr_pkg::ST_OK; ol_in = len_ff;
            state_in = S_IDLE;
         end
         S_WCRC0: begin
            a        = wrap_ptr(cur_ff, size);
            mem_we   = 1'b1; mem_addr = a; mem_wd = chk[15:8];
            cur_in   = {1'b0, a} + 1'b1;
            state_in = S_WCRC1;
         end
         S_WCRC1: begin
            a        = wrap_ptr(cur_ff, size);
            a_next   = {1'b0, a} + 1'b1;
            mem_we   = 1'b1; mem_addr = a; mem_wd = chk[7:0];
            cur_in   = a_next; wptr_in = a_next; mode_in = M_IDLE;
            rv_in    = 1'b1; st_in = crcfr_pkg::ST_OK; last_in = 1'b1;
            state_in = S_IDLE;
         end
         S_RH1: begin
            lo_in    = rd_data_ff;
            a        = wrap_ptr(tp_ff, size);
            mem_re   = 1'b1; mem_addr = a;
            tp_in    = {1'b0, a} + 1'b1;
            state_in = S_RH2;
         end
         S_RH2: begin
            rv_in    = 1'b1;
            state_in = S_IDLE;
            if (osz == 16'd0) st_in = crcfr_pkg::ST_EMPTY;
            else if (osz > len_ff) st_in = crcfr_pkg::ST_CAPACITY;
            else if (osz > 16'(size)) st_in = crcfr_pkg::ST_RING;
            else begin
               cur_in = tp_ff; bl_in = osz; crc_in = 16'hFFFF; mode_in = M_READ;
               st_in  = crcfr_pkg::ST_OK; ol_in = osz;
            end
         end
         S_RB1: begin
            crc_new = crc_byte(crc_ff, rd_data_ff);
            dout_in = rd_data_ff;
            crc_in  = crc_new;
            bl_in   = bl_dec;
            if (bl_dec != 16'd0) begin
               rv_in = 1'b1; st_in = crcfr_pkg::ST_OK; od_in = rd_data_ff;
               state_in = S_IDLE;
            end else begin
               a        = wrap_ptr(cur_ff, size);
               mem_re   = 1'b1; mem_addr = a;
               cur_in   = {1'b0, a} + 1'b1;
               state_in = S_RC1;
            end
         end
         S_RC1: begin
            s0_in    = rd_data_ff;
            a        = wrap_ptr(cur_ff, size);
            mem_re   = 1'b1; mem_addr = a;
            cur_in   = {1'b0, a} + 1'b1;
            state_in = S_RC2;
         end
         S_RC2: begin
            mode_in = M_IDLE;
            if (s0_ff == chk[15:8] && rd_data_ff == chk[7:0]) begin
               // good frame: fetch its header again to size the wipe
               a        = wrap_ptr(rptr_ff, size);
               mem_re   = 1'b1; mem_addr = a;
               tp_in    = {1'b0, a} + 1'b1;
               state_in = S_RZ1;
            end else begin
               rv_in = 1'b1; st_in = crcfr_pkg::ST_CRC; od_in = dout_ff; last_in = 1'b1;
               state_in = S_IDLE;
            end
         end
         S_RZ1: begin
            lo_in    = rd_data_ff;
            a        = wrap_ptr(tp_ff, size);
            mem_re   = 1'b1; mem_addr = a;
            state_in = S_RZ2;
         end
         S_RZ2: begin
            flen = {1'b0, osz} + 17'd4;
            if (flen > 17'(size)) flen = 17'(size);
            cnt_in   = flen[PW-1:0];
            tp_in    = rptr_ff;
            state_in = S_ZERO;
         end
         S_ZERO: begin
            if (cnt_ff != '0) begin
               a      = wrap_ptr(tp_ff, size);
               mem_we = 1'b1; mem_addr = a;
               tp_in  = {1'b0, a} + 1'b1;
               cnt_in = cnt_ff - 1'b1;
            end else begin
               rptr_in = {1'b0, wrap_ptr(cur_ff, size)};
               rv_in = 1'b1; st_in = crcfr_pkg::ST_OK; od_in = dout_ff; last_in = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) mem[mem_addr] <= mem_wd;
      if (mem_re) rd_data_ff <= mem[mem_addr];
   end

   always_ff @(posedge clock) begin
      len_ff <= len_in; lo_ff <= lo_in; s0_ff <= s0_in; dout_ff <= dout_in;
      st_ff <= st_in; od_ff <= od_in; ol_ff <= ol_in; last_ff <= last_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR; mode_ff <= M_IDLE;
         wptr_ff <= '0; rptr_ff <= '0; cur_ff <= '0; tp_ff <= '0; cnt_ff <= '0;
         bl_ff <= 16'd0; crc_ff <= 16'hFFFF; err_ff <= 32'd0; pend_ff <= 1'b0;
         rv_ff <= 1'b0; ring_ff <= 11'(crcfr_pkg::RING_DEPTH);
      end else begin
         state_ff <= state_in; mode_ff <= mode_in;
         wptr_ff <= wptr_in; rptr_ff <= rptr_in; cur_ff <= cur_in; tp_ff <= tp_in;
         cnt_ff <= cnt_in; bl_ff <= bl_in; crc_ff <= crc_in; err_ff <= err_in;
         pend_ff <= pend_in; rv_ff <= rv_in;
         if (csr_valid) ring_ff <= csr_ring_bytes;
      end
   end

endmodule

>>> src/crc_framed_ring_message_store.sv
// ---------------------------------------------------------------------------
// crc_framed_ring_message_store: framed byte ring with CRC-16/X.25
// Stores length-prefixed, CRC-terminated messages in a ring of up to 1024 bytes.
// ---------------------------------------------------------------------------
// After reset the ring memory is swept to zero, during which req_ready stays
// low (csr writes are still taken). Items then run one at a time through a
// single-port sequencer on the ring memory, and the next item starts only
// after the previous response has left the response register. A write_byte
// stores its byte, and the last one also appends the CRC; a begin_read
// fetches the header; a begin_write scans for free space, then writes the
// header. A read_byte returns its byte; the last one also checks the CRC and,
// when it matches, wipes the frame (the wipe stops at one lap of the ring).
// A two-entry request queue keeps taking request beats, until it is full,
// while the sequencer is busy or the response side stalls.
module crc_framed_ring_message_store (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_action,
   input  logic [7:0]  req_data_in,
   input  logic [15:0] req_length,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [3:0]  rsp_status,
   output logic [7:0]  rsp_data_out,
   output logic [15:0] rsp_obj_len,
   output logic        rsp_last,
   output logic [31:0] rsp_write_errors,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [10:0] csr_ring_bytes
);

   logic                clearing;
   logic                q_valid;
   logic                q_pop;
   crcfr_pkg::item_type q_item;

   assign csr_ready = 1'b1;

   crcfr_front u_front (
      .clock, .reset, .req_valid, .req_ready, .req_action, .req_data_in, .req_length,
      .clearing, .q_valid, .q_item, .q_pop
   );

   crcfr_back u_back (
      .clock, .reset, .csr_valid, .csr_ring_bytes, .clearing, .q_valid, .q_item, .q_pop,
      .rsp_valid, .rsp_ready, .rsp_status, .rsp_data_out, .rsp_obj_len, .rsp_last,
      .rsp_write_errors
   );

   a_status_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_status <= crcfr_pkg::ST_SEQUENCE)
      else $error("status code out of range");

   a_last_status: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_last) |->
         (rsp_status == crcfr_pkg::ST_OK || rsp_status == crcfr_pkg::ST_CRC))
      else $error("last flagged on a failed item");

   a_err_step: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) |-> (rsp_write_errors == $past(rsp_write_errors) ||
                         rsp_write_errors == $past(rsp_write_errors) + 32'd1))
      else $error("write error count jumped");

endmodule

>>> tb/sv/crc_store_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// crc_store_checker: response checker for the framed ring message store
// Watches request, response and csr beats, keeps its own copy of the ring and
// its pointers, predicts one response per request and compares field by field.
// ----------------------------------------------------------------------------
module crc_store_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_ready,
   input  logic [1:0]  req_action,
   input  logic [7:0]  req_data_in,
   input  logic [15:0] req_length,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  logic [3:0]  rsp_status,
   input  logic [7:0]  rsp_data_out,
   input  logic [15:0] rsp_obj_len,
   input  logic        rsp_last,
   input  logic [31:0] rsp_write_errors,
   input  logic        csr_valid,
   input  logic        csr_ready,
   input  logic [10:0] csr_ring_bytes,
   output int          mismatches,
   output int          pending
);

   typedef enum logic [1:0] {MODE_IDLE, MODE_WRITING, MODE_READING} store_mode_type;

   typedef struct packed {
      logic [3:0]  status;
      logic [7:0]  data_out;
      logic [15:0] obj_len;
      logic        last;
      logic [31:0] write_errors;
   } store_rsp_type;

   logic [7:0]     ring_mem [crcfr_pkg::RING_DEPTH];
   int             wr_ptr, rd_ptr, cur_ptr;
   logic [15:0]    bytes_left;
   logic [15:0]    crc_acc;
   store_mode_type mode;
   logic [31:0]    reject_count;
   logic [10:0]    ring_cfg;
   store_rsp_type  expected_rsp_q[$];

   function automatic int ring_size();
      int s;
      s = int'(ring_cfg);
      if (s < 8) s = 8;
      if (s > crcfr_pkg::RING_DEPTH) s = crcfr_pkg::RING_DEPTH;
      return s;
   endfunction

   function automatic int wrapped(int p);
      return (p >= ring_size()) ? 0 : p;
   endfunction

   function automatic void poke(inout int p, input logic [7:0] v);
      int a;
      a = wrapped(p);
      ring_mem[a] = v;
      p = a + 1;
   endfunction

   function automatic logic [7:0] peek(inout int p);
      int a;
      a = wrapped(p);
      p = a + 1;
      return ring_mem[a];
   endfunction

   function automatic logic [15:0] crc_x25_byte(logic [15:0] c, logic [7:0] d);
      for (int i = 0; i < 8; i++) begin
         if (c[0] ^ d[i]) c = (c >> 1) ^ 16'h8408;
         else c = c >> 1;
      end
      return c;
   endfunction

   function automatic store_rsp_type predict_store_rsp(logic [1:0] act, logic [7:0] din,
                                                       logic [15:0] len);
      store_rsp_type r;
      int            size, p, n, osz, flen;
      logic          room;
      logic [15:0]   chk;
      logic [7:0]    s0, s1;
      size = ring_size();
      r = '0;
      r.status = crcfr_pkg::ST_SEQUENCE;
      if (act == crcfr_pkg::ACT_BEGIN_WRITE && mode == MODE_IDLE) begin
         if (int'(len) > size - 4) r.status = crcfr_pkg::ST_TOO_BIG;
         else if (len == 16'd0) r.status = crcfr_pkg::ST_ZERO_LEN;
         else begin
            p = wr_ptr;
            room = 1'b1;
            for (n = 0; n < int'(len) + 6; n++) begin
               if (peek(p) != 8'd0) begin
                  room = 1'b0;
                  break;
               end
            end
            if (!room) r.status = crcfr_pkg::ST_NO_ROOM;
            else begin
               cur_ptr = wr_ptr;
               poke(cur_ptr, len[7:0]);
               poke(cur_ptr, len[15:8]);
               bytes_left = len;
               crc_acc = 16'hFFFF;
               mode = MODE_WRITING;
               r.status = crcfr_pkg::ST_OK;
               r.obj_len = len;
            end
         end
         if (r.status != crcfr_pkg::ST_OK) reject_count = reject_count + 32'd1;
      end else if (act == crcfr_pkg::ACT_WRITE_BYTE && mode == MODE_WRITING) begin
         poke(cur_ptr, din);
         crc_acc = crc_x25_byte(crc_acc, din);
         bytes_left = bytes_left - 16'd1;
         r.status = crcfr_pkg::ST_OK;
         if (bytes_left == 16'd0) begin
            chk = ~crc_acc;
            poke(cur_ptr, chk[15:8]);
            poke(cur_ptr, chk[7:0]);
            wr_ptr = cur_ptr;
            mode = MODE_IDLE;
            r.last = 1'b1;
         end
      end else if (act == crcfr_pkg::ACT_BEGIN_READ && mode == MODE_IDLE) begin
         p = rd_ptr;
         osz = int'(peek(p));
         osz = osz | (int'(peek(p)) << 8);
         if (osz == 0) r.status = crcfr_pkg::ST_EMPTY;
         else if (osz > int'(len)) r.status = crcfr_pkg::ST_CAPACITY;
         else if (osz > size) r.status = crcfr_pkg::ST_RING;
         else begin
            cur_ptr = p;
            bytes_left = osz[15:0];
            crc_acc = 16'hFFFF;
            mode = MODE_READING;
            r.status = crcfr_pkg::ST_OK;
            r.obj_len = osz[15:0];
         end
      end else if (act == crcfr_pkg::ACT_READ_BYTE && mode == MODE_READING) begin
         r.data_out = peek(cur_ptr);
         crc_acc = crc_x25_byte(crc_acc, r.data_out);
         bytes_left = bytes_left - 16'd1;
         r.status = crcfr_pkg::ST_OK;
         if (bytes_left == 16'd0) begin
            chk = ~crc_acc;
            s0 = peek(cur_ptr);
            s1 = peek(cur_ptr);
            r.last = 1'b1;
            mode = MODE_IDLE;
            if (s0 == chk[15:8] && s1 == chk[7:0]) begin
               // wipe the frame, at most one full lap of the ring
               p = rd_ptr;
               flen = int'(peek(p));
               flen = (flen | (int'(peek(p)) << 8)) + 4;
               if (flen > size) flen = size;
               p = rd_ptr;
               for (n = 0; n < flen; n++) poke(p, 8'd0);
               rd_ptr = wrapped(cur_ptr);
            end else begin
               r.status = crcfr_pkg::ST_CRC;
            end
         end
      end
      r.write_errors = reject_count;
      return r;
   endfunction

   task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
      $display("%0t: mismatch on %s: got 0x%0h, want 0x%0h", $realtime, what, got, want);
      mismatches++;
   endtask

   initial begin
      mismatches = 0;
      pending = 0;
   end

   always @(posedge clock) begin
      store_rsp_type want;
      if (reset) begin
         foreach (ring_mem[i]) ring_mem[i] = 8'd0;
         wr_ptr = 0;
         rd_ptr = 0;
         cur_ptr = 0;
         bytes_left = '0;
         crc_acc = 16'hFFFF;
         mode = MODE_IDLE;
         reject_count = '0;
         ring_cfg = 11'd1024;
         expected_rsp_q.delete();
      end else begin
         if (csr_valid && csr_ready) ring_cfg = csr_ring_bytes;
         if (req_valid && req_ready)
            expected_rsp_q.push_back(predict_store_rsp(req_action, req_data_in, req_length));
         if (rsp_valid && rsp_ready) begin
            if (expected_rsp_q.size() == 0) begin
               report_mismatch("unexpected response, status", 32'(rsp_status), 32'd0);
            end else begin
               want = expected_rsp_q.pop_front();
               if (rsp_status != want.status)
                  report_mismatch("status", 32'(rsp_status), 32'(want.status));
               if (rsp_data_out != want.data_out)
                  report_mismatch("data_out", 32'(rsp_data_out), 32'(want.data_out));
               if (rsp_obj_len != want.obj_len)
                  report_mismatch("obj_len", 32'(rsp_obj_len), 32'(want.obj_len));
               if (rsp_last != want.last)
                  report_mismatch("last", 32'(rsp_last), 32'(want.last));
               if (rsp_write_errors != want.write_errors)
                  report_mismatch("write_errors", rsp_write_errors, want.write_errors);
            end
         end
      end
      pending = expected_rsp_q.size();
   end

endmodule

>>> tb/sv/tb_crc_framed_ring_message_store.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_crc_framed_ring_message_store: stimulus and verdict for the ring store
// Drives framed writes and reads with random content, broken sequences and
// noise across several ring sizes; the checker beside the block compares.
// ----------------------------------------------------------------------------
module tb_crc_framed_ring_message_store;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [1:0]  req_action = crcfr_pkg::ACT_BEGIN_READ;
   logic [7:0]  req_data_in = '0;
   logic [15:0] req_length = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [3:0]  rsp_status;
   logic [7:0]  rsp_data_out;
   logic [15:0] rsp_obj_len;
   logic        rsp_last;
   logic [31:0] rsp_write_errors;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [10:0] csr_ring_bytes = '0;

   int          mismatches;
   int          pending;
   int          beats_sent = 0;
   int          beats_back = 0;
   logic [3:0]  last_status = crcfr_pkg::ST_OK;
   logic [15:0] last_obj_len = '0;
   logic        quiet = 1'b0;
   int          stall_left = 0;
   int          ring_now = 1024;

   always #2 clock = ~clock;

   crc_framed_ring_message_store i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_action       (req_action),
      .req_data_in      (req_data_in),
      .req_length       (req_length),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_status       (rsp_status),
      .rsp_data_out     (rsp_data_out),
      .rsp_obj_len      (rsp_obj_len),
      .rsp_last         (rsp_last),
      .rsp_write_errors (rsp_write_errors),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_ring_bytes   (csr_ring_bytes)
   );

   crc_store_checker i_checker (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_action       (req_action),
      .req_data_in      (req_data_in),
      .req_length       (req_length),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_status       (rsp_status),
      .rsp_data_out     (rsp_data_out),
      .rsp_obj_len      (rsp_obj_len),
      .rsp_last         (rsp_last),
      .rsp_write_errors (rsp_write_errors),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_ring_bytes   (csr_ring_bytes),
      .mismatches       (mismatches),
      .pending          (pending)
   );

   // response side: random stall bursts, none once quiet
   always @(posedge clock) begin
      if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_ready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
         stall_left <= int'($urandom_range(0, 11));
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
      if (rsp_valid && rsp_ready) begin
         beats_back <= beats_back + 1;
         last_status <= rsp_status;
         last_obj_len <= rsp_obj_len;
      end
   end

   task automatic send_beat(logic [1:0] act, logic [7:0] din, logic [15:0] len);
      if (!quiet && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 12)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_action <= act;
      req_data_in <= din;
      req_length <= len;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      beats_sent++;
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (beats_back < beats_sent) @(posedge clock);
   endtask

   // begin_write, then the payload if accepted; broken optionally splices in
   // an out-of-order begin_read halfway
   task automatic frame_write(int len, bit broken);
      send_beat(crcfr_pkg::ACT_BEGIN_WRITE, 8'($urandom), len[15:0]);
      drain();
      if (last_status == crcfr_pkg::ST_OK) begin
         for (int i = 0; i < len; i++) begin
            if (broken && i == len / 2)
               send_beat(crcfr_pkg::ACT_BEGIN_READ, 8'($urandom), 16'($urandom));
            send_beat(crcfr_pkg::ACT_WRITE_BYTE, 8'($urandom), 16'($urandom));
         end
      end
   endtask

   task automatic frame_read(logic [15:0] cap, bit broken);
      int n;
      send_beat(crcfr_pkg::ACT_BEGIN_READ, 8'($urandom), cap);
      drain();
      if (last_status == crcfr_pkg::ST_OK) begin
         n = int'(last_obj_len);
         for (int i = 0; i < n; i++) begin
            if (broken && i == n / 2)
               send_beat(crcfr_pkg::ACT_BEGIN_WRITE, 8'($urandom), 16'($urandom));
            send_beat(crcfr_pkg::ACT_READ_BYTE, 8'($urandom), 16'($urandom));
         end
      end
   endtask

   task automatic set_ring_bytes(logic [10:0] v);
      drain();
      repeat (40) @(posedge clock);
      csr_valid <= 1'b1;
      csr_ring_bytes <= v;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      ring_now = (v < 11'd8) ? 8 : ((v > 11'd1024) ? 1024 : int'(v));
      @(posedge clock);
   endtask

   task automatic random_traffic(int count);
      int goal, pick, len, lim;
      goal = beats_sent + count;
      lim = ring_now - 4;
      while (beats_sent < goal) begin
         pick = int'($urandom_range(0, 99));
         if (pick < 42) begin
            if ($urandom_range(0, 19) == 0) len = int'($urandom_range(1, lim));
            else len = int'($urandom_range(1, (lim < 16) ? lim : 16));
            frame_write(len, $urandom_range(0, 19) == 0);
         end else if (pick < 84) begin
            frame_read(($urandom_range(0, 6) == 0) ? 16'($urandom) : 16'hFFFF,
                       $urandom_range(0, 19) == 0);
         end else begin
            case ($urandom_range(0, 3))
               0: frame_write(($urandom_range(0, 1) == 0) ? int'($urandom_range(0, 65535)) : 0,
                              1'b0);
               1: frame_read(16'($urandom), 1'b0);
               2: send_beat(crcfr_pkg::ACT_WRITE_BYTE, 8'($urandom), 16'($urandom));
               default: send_beat(crcfr_pkg::ACT_READ_BYTE, 8'($urandom), 16'($urandom));
            endcase
         end
      end
   endtask

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: empty store, stray bytes, bad lengths, short frames
      send_beat(crcfr_pkg::ACT_BEGIN_READ, 8'h00, 16'hFFFF);
      send_beat(crcfr_pkg::ACT_WRITE_BYTE, 8'hFF, 16'hFFFF);
      send_beat(crcfr_pkg::ACT_READ_BYTE, 8'h00, 16'h0000);
      send_beat(crcfr_pkg::ACT_BEGIN_WRITE, 8'h00, 16'd0);
      send_beat(crcfr_pkg::ACT_BEGIN_WRITE, 8'h00, 16'hFFFF);
      send_beat(crcfr_pkg::ACT_BEGIN_WRITE, 8'h00, 16'd1021);
      drain();
      send_beat(crcfr_pkg::ACT_BEGIN_WRITE, 8'h00, 16'd3);
      send_beat(crcfr_pkg::ACT_WRITE_BYTE, 8'hFF, 16'h0000);
      send_beat(crcfr_pkg::ACT_BEGIN_READ, 8'h00, 16'hFFFF);
      send_beat(crcfr_pkg::ACT_WRITE_BYTE, 8'h00, 16'hFFFF);
      send_beat(crcfr_pkg::ACT_WRITE_BYTE, 8'hA5, 16'h0000);
      send_beat(crcfr_pkg::ACT_BEGIN_READ, 8'h00, 16'd2);
      send_beat(crcfr_pkg::ACT_BEGIN_READ, 8'h00, 16'd3);
      send_beat(crcfr_pkg::ACT_READ_BYTE, 8'h00, 16'h0000);
      send_beat(crcfr_pkg::ACT_BEGIN_WRITE, 8'h00, 16'd1);
      send_beat(crcfr_pkg::ACT_READ_BYTE, 8'h00, 16'h0000);
      send_beat(crcfr_pkg::ACT_READ_BYTE, 8'h00, 16'h0000);
      send_beat(crcfr_pkg::ACT_BEGIN_READ, 8'h00, 16'hFFFF);
      frame_write(1, 1'b0);

      // leave frames behind across size changes: wraps, stale headers, bad crc
      random_traffic(110);
      set_ring_bytes(11'd8);
      random_traffic(110);
      set_ring_bytes(11'd2047);
      random_traffic(110);
      set_ring_bytes(11'd0);
      random_traffic(100);
      set_ring_bytes(11'd64);
      random_traffic(110);
      set_ring_bytes(11'd1021);
      random_traffic(110);
      set_ring_bytes(11'd300);
      random_traffic(110);
      set_ring_bytes(11'd1023);
      random_traffic(100);
      set_ring_bytes(11'd1024);
      quiet = 1'b1;
      random_traffic(100);

      drain();
      repeat (100) @(posedge clock);
      if (mismatches == 0 && pending == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

   initial begin
      #4000000;
      $display("[FAIL] regression broken");
      $finish;
   end

endmodule
